[sv/sae_pkg.sv]
// Package for the set algebra engine: transaction structs, action codes and status codes.
// Used by every module of the block. It depends on nothing.
`default_nettype none
package sae_pkg;

	typedef enum logic [3:0] {
		ACT_CLEAR    = 4'd0,
		ACT_INS_A    = 4'd1,
		ACT_INS_B    = 4'd2,
		ACT_SUBSET   = 4'd3,
		ACT_UNION    = 4'd4,
		ACT_INTERSECT = 4'd5,
		ACT_A_MINUS_B = 4'd6,
		ACT_SYMDIFF  = 4'd7,
		ACT_COMPL    = 4'd8
	} action_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DUP     = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NOT_SUB = 2'd3;

	typedef struct packed {
		logic [3:0]         action;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               has_element;
		logic               last;
		logic [1:0]         status;
		logic               is_subset;
	} out_item_t;

	// Broadcast from the sequencer to every cell of one chain.
	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

[sv/sae_cell.sv]
// One cell of a set chain: holds one element and compares it with a broadcast probe.
// Depends on sae_pkg for the control struct.
`default_nettype none
module sae_cell #(
	parameter int W = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sae_pkg::cell_ctrl_t ctrl,
	input  wire                  is_tail,
	input  wire  [W-1:0]         load_data,
	input  wire                  nb_valid,
	input  wire  [W-1:0]         nb_data,
	input  wire  [W-1:0]         probe,
	output logic                 valid,
	output logic [W-1:0]         data,
	output logic                 hit
);

	logic         valid_q;
	logic [W-1:0] data_q;

	// A load writes only the first empty cell; a shift takes the neighbour's contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nb_valid;
		end else if (ctrl.load && is_tail) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= nb_data;
		end else if (ctrl.load && is_tail) begin
			data_q <= load_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	assign hit   = valid_q && (data_q == probe);

endmodule
`default_nettype wire

[sv/sae_chain.sv]
// A chain of set cells for one set, with rotation so the head can be streamed out.
// Depends on sae_pkg and sae_cell.
`default_nettype none
module sae_chain #(
	parameter int CAP = 16,
	parameter int W   = 32
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sae_pkg::cell_ctrl_t ctrl,
	input  wire  [W-1:0]         load_data,
	input  wire  [W-1:0]         probe,
	output logic                 member,
	output logic [W-1:0]         head
);

	logic [CAP-1:0]        valid;
	logic [CAP-1:0]        hit;
	logic [CAP-1:0][W-1:0] data;
	logic [CAP-1:0]        tail;
	logic [CAP-1:0]        nb_valid;
	logic [CAP-1:0][W-1:0] nb_data;

	// The tail is the first empty cell; cells fill in insertion order.
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			if (i == 0) tail[i] = !valid[0];
			else        tail[i] = !valid[i] && valid[i-1];
		end
	end

	// Rotation by one within the filled cells: each cell takes its upper neighbour,
	// and the last filled cell takes the head, so a full pass restores the order.
	always_comb begin
		for (int i = 0; i < CAP-1; i++) begin
			if (valid[i+1]) begin
				nb_valid[i] = 1'b1;
				nb_data[i]  = data[i+1];
			end else begin
				nb_valid[i] = valid[i];
				nb_data[i]  = data[0];
			end
		end
		nb_valid[CAP-1] = valid[CAP-1];
		nb_data[CAP-1]  = data[0];
	end

	for (genvar g = 0; g < CAP; g++) begin : g_cell
		sae_cell #(.W(W)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .is_tail(tail[g]),
			.load_data(load_data),
			.nb_valid(nb_valid[g]), .nb_data(nb_data[g]),
			.probe(probe), .valid(valid[g]), .data(data[g]), .hit(hit[g])
		);
	end

	assign member = |hit;
	assign head   = data[0];

endmodule
`default_nettype wire

[sv/set_algebra_engine_core.sv]
// Top level of the set algebra engine: sequencer, two cell chains and the output register.
// Depends on sae_pkg, sae_chain and sae_cell.
//
//  channel | direction | handshake     | payload
//  in      | input     | valid / stall | sae_pkg::in_item_t  (action, value)
//  out     | output    | valid / stall | sae_pkg::out_item_t (element .. is_subset)
//
// Inserts, clear and the subset query each end in one result item; a streaming query
// rotates the cell chains, and the comparators in every cell test the broadcast head
// of the rotating chain against the other set.
// arst_n clears both sets and the sequencer. A stalled output holds the sequencer.
`default_nettype none
module set_algebra_engine_core #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire sae_pkg::in_item_t in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output sae_pkg::out_item_t  out_data
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_PASSA = 5'b00100,
		S_PASSB = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                  state_q;
	sae_pkg::action_t        act_q;
	logic [ELEM_WIDTH-1:0]   val_q;
	logic [CW-1:0]           cnt_a_q, cnt_b_q, idx_q;
	logic                    flag_q, any_q, hold_q;
	logic [1:0]              st_q;
	logic                    out_valid_q;
	sae_pkg::out_item_t      out_q;
	sae_pkg::out_item_t      held_q;

	sae_pkg::cell_ctrl_t     ctrl_a, ctrl_b;
	logic [ELEM_WIDTH-1:0]   probe, head_a, head_b;
	logic                    mem_a, mem_b;
	logic                    busy;
	logic                    emit, emit_last, emit_has;
	logic [ELEM_WIDTH-1:0]   emit_elem;
	logic [1:0]              emit_st;
	logic                    emit_sub;
	sae_pkg::out_item_t      emit_item;
	sae_pkg::out_item_t      held_last;
	logic                    can_emit;
	logic                    accept;
	logic                    pass_end;
	logic [CW-1:0]           pass_cnt;
	logic                    pass_empty;
	logic                    pass_go;
	logic                    to_passb;
	state_t                  pass_next;
	logic                    compl_fin;
	logic                    compl_ok;
	logic                    out_load;

	assign busy     = (state_q != S_IDLE);
	assign in_stall = busy;
	assign accept   = in_valid && !busy;
	assign can_emit = !out_valid_q || !out_stall;

	// The probe is the new value outside the passes, and the head of the rotating chain during a pass.
	always_comb begin
		probe = val_q;
		if (state_q == S_PASSA) probe = head_a;
		else if (state_q == S_PASSB) probe = head_b;
	end

	// Pass bookkeeping: the rotating set's count, its end and the state that follows.
	assign pass_cnt   = (state_q == S_PASSA) ? cnt_a_q : cnt_b_q;
	assign pass_empty = (pass_cnt == '0);
	assign pass_end   = (idx_q + 1'b1 >= pass_cnt);
	assign pass_go    = can_emit && !hold_q && !pass_empty;
	assign to_passb   = (state_q == S_PASSA) && (act_q != sae_pkg::ACT_INTERSECT) &&
	                    (act_q != sae_pkg::ACT_A_MINUS_B);
	assign pass_next  = (act_q == sae_pkg::ACT_SUBSET) ? S_CHECK : S_DONE;
	assign compl_fin  = (state_q == S_PASSA) && (act_q == sae_pkg::ACT_COMPL) &&
	                    (pass_empty || (pass_go && pass_end));
	assign compl_ok   = flag_q && (pass_empty || mem_b);

	// Sequencer decisions: rotate, load, clear and emit.
	always_comb begin
		ctrl_a = '0;
		ctrl_b = '0;
		emit = 1'b0; emit_last = 1'b0; emit_has = 1'b0;
		emit_elem = '0; emit_st = sae_pkg::ST_OK; emit_sub = 1'b0;
		unique case (state_q)
			S_CHECK: begin
				if (can_emit) begin
					emit = 1'b1; emit_last = 1'b1;
					unique case (act_q)
						sae_pkg::ACT_CLEAR: begin
							ctrl_a.clear = 1'b1; ctrl_b.clear = 1'b1;
						end
						sae_pkg::ACT_INS_A: begin
							if (mem_a) emit_st = sae_pkg::ST_DUP;
							else if (cnt_a_q >= CW'(CAPACITY)) emit_st = sae_pkg::ST_FULL;
							else ctrl_a.load = 1'b1;
						end
						sae_pkg::ACT_INS_B: begin
							if (mem_b) emit_st = sae_pkg::ST_DUP;
							else if (cnt_b_q >= CW'(CAPACITY)) emit_st = sae_pkg::ST_FULL;
							else ctrl_b.load = 1'b1;
						end
						default: emit_sub = flag_q;
					endcase
				end
			end
			S_PASSA, S_PASSB: begin
				if (pass_go) begin
					if (state_q == S_PASSA) ctrl_a.shift = 1'b1;
					else ctrl_b.shift = 1'b1;
					emit_elem = probe;
					emit_has  = 1'b1;
					emit_st   = st_q;
					if (state_q == S_PASSA) begin
						unique case (act_q)
							sae_pkg::ACT_INTERSECT: emit = mem_b;
							sae_pkg::ACT_UNION:     emit = 1'b1;
							sae_pkg::ACT_COMPL:     emit = 1'b0;
							default:                emit = !mem_b;
						endcase
					end else if (act_q == sae_pkg::ACT_SUBSET) begin
						emit = 1'b0;
					end else begin
						emit = (act_q == sae_pkg::ACT_COMPL && flag_q) ? 1'b1 : !mem_a;
					end
				end
			end
			S_DONE: begin
				if (can_emit && !any_q) begin
					emit = 1'b1; emit_last = 1'b1; emit_st = st_q;
				end
			end
			default: ;
		endcase
	end

	assign emit_item = '{element: 32'(emit_elem), has_element: emit_has, last: emit_last,
	                     status: emit_st, is_subset: emit_sub};

	always_comb begin
		held_last      = held_q;
		held_last.last = 1'b1;
	end

	// The output register takes a new item in these cycles.
	assign out_load = (state_q == S_DONE) ? can_emit :
	                  (emit && (state_q == S_CHECK || any_q));

	// Sequencer state. Streamed results are held one item back so the final one can be
	// marked last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_a_q <= '0; cnt_b_q <= '0; idx_q <= '0;
			flag_q <= 1'b0; any_q <= 1'b0; hold_q <= 1'b0;
			st_q <= sae_pkg::ST_OK;
			act_q <= sae_pkg::ACT_CLEAR;
			val_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (ctrl_a.clear) begin
				cnt_a_q <= '0; cnt_b_q <= '0;
			end else begin
				if (ctrl_a.load) cnt_a_q <= cnt_a_q + 1'b1;
				if (ctrl_b.load) cnt_b_q <= cnt_b_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_data.action <= 4'(sae_pkg::ACT_COMPL)) begin
						act_q  <= sae_pkg::action_t'(in_data.action);
						val_q  <= ELEM_WIDTH'($unsigned(in_data.value));
						idx_q  <= '0;
						any_q  <= 1'b0;
						hold_q <= 1'b0;
						st_q   <= sae_pkg::ST_OK;
						flag_q <= 1'b1;
						if (in_data.action >= 4'(sae_pkg::ACT_UNION)) state_q <= S_PASSA;
						else if (in_data.action == 4'(sae_pkg::ACT_SUBSET)) state_q <= S_PASSB;
						else state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (emit) state_q <= S_IDLE;
				end
				S_PASSA, S_PASSB: begin
					// Complement: the pass over A only checks A within B.
					if (compl_fin) begin
						st_q   <= compl_ok ? sae_pkg::ST_OK : sae_pkg::ST_NOT_SUB;
						flag_q <= !compl_ok;
					end else if (pass_go && ((state_q == S_PASSA &&
					             act_q == sae_pkg::ACT_COMPL && !mem_b) ||
					             (act_q == sae_pkg::ACT_SUBSET && !mem_a))) begin
						flag_q <= 1'b0;
					end
					if (pass_go && emit) any_q <= 1'b1;
					hold_q <= pass_empty || (pass_go && pass_end);
					if (pass_empty || (pass_go && pass_end)) begin
						idx_q   <= '0;
						state_q <= to_passb ? S_PASSB : pass_next;
					end else if (pass_go) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DONE: begin
					if (can_emit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Held item: the newest streamed element, waiting until the next one shows it is
	// not the final one.
	always_ff @(posedge clk) begin
		if (emit && (state_q == S_PASSA || state_q == S_PASSB)) held_q <= emit_item;
	end

	// Output register: written when the previous item is handed over or the slot is
	// free; at the end the held item goes out with its last flag set.
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_DONE && any_q) out_q <= held_last;
			else if (state_q == S_PASSA || state_q == S_PASSB) out_q <= held_q;
			else out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	sae_chain #(.CAP(CAPACITY), .W(ELEM_WIDTH)) u_chain_a (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_a), .load_data(val_q),
		.probe(probe), .member(mem_a), .head(head_a)
	);

	sae_chain #(.CAP(CAPACITY), .W(ELEM_WIDTH)) u_chain_b (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl_b), .load_data(val_q),
		.probe(probe), .member(mem_b), .head(head_b)
	);

	// No new transaction while the sequencer is busy.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("accepted while busy");
	// Set counts never exceed the capacity.
	a_cnt_a: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_a_q <= CW'(CAPACITY)) else $error("set A overfull");
	a_cnt_b: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_b_q <= CW'(CAPACITY)) else $error("set B overfull");
	// A held result is never overwritten while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for set_algebra_engine_core: set inserts, clear and the set queries.
// Depends on sae_pkg and the core; a scoreboard class predicts the results of every transaction.
`timescale 1ns / 100ps
`default_nettype none

module testbench;

	localparam int CAP = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	// Predictor of both sets with a queue of expected result transactions.
	class set_scoreboard;
		logic [31:0] a_elems[CAP];
		logic [31:0] b_elems[CAP];
		int a_num;
		int b_num;
		sae_pkg::out_item_t pending[$];
		int errors;

		function new();
			a_num = 0;
			b_num = 0;
			errors = 0;
		endfunction

		function automatic bit holds(bit in_b, logic [31:0] v);
			bit hit;
			hit = 0;
			for (int i = 0; i < (in_b ? b_num : a_num); i++)
				if ((in_b ? b_elems[i] : a_elems[i]) == v)
					hit = 1;
			return hit;
		endfunction

		function automatic void push(logic [31:0] e, bit has, logic [1:0] st, bit sub);
			sae_pkg::out_item_t r;
			r.element = has ? e : '0;
			r.has_element = has;
			r.last = 1'b0;
			r.status = st;
			r.is_subset = sub;
			pending.push_back(r);
		endfunction

		// Elements of one set that are (or are not) in the other; an empty other set when skip.
		function automatic int stream(bit from_b, bit want_in, bit skip, logic [1:0] st);
			int n;
			logic [31:0] v;
			n = 0;
			for (int i = 0; i < (from_b ? b_num : a_num); i++) begin
				v = from_b ? b_elems[i] : a_elems[i];
				if ((!skip && holds(!from_b, v)) == want_in) begin
					push(v, 1, st, 0);
					n++;
				end
			end
			return n;
		endfunction

		function automatic void note_input(sae_pkg::in_item_t it);
			int n;
			bit ok;
			logic [1:0] st;
			logic [31:0] v;
			n = 0;
			st = sae_pkg::ST_OK;
			v = it.value;
			case (it.action)
				sae_pkg::ACT_CLEAR: begin
					a_num = 0;
					b_num = 0;
					push(0, 0, sae_pkg::ST_OK, 0);
					n = 1;
				end
				sae_pkg::ACT_INS_A, sae_pkg::ACT_INS_B: begin
					if (holds(it.action == sae_pkg::ACT_INS_B, v))
						st = sae_pkg::ST_DUP;
					else if ((it.action == sae_pkg::ACT_INS_B ? b_num : a_num) >= CAP)
						st = sae_pkg::ST_FULL;
					else if (it.action == sae_pkg::ACT_INS_B) begin
						b_elems[b_num] = v;
						b_num++;
					end else begin
						a_elems[a_num] = v;
						a_num++;
					end
					push(0, 0, st, 0);
					n = 1;
				end
				sae_pkg::ACT_SUBSET: begin
					ok = 1;
					for (int i = 0; i < b_num; i++)
						if (!holds(0, b_elems[i]))
							ok = 0;
					push(0, 0, sae_pkg::ST_OK, ok);
					n = 1;
				end
				sae_pkg::ACT_UNION: begin
					n = stream(0, 0, 1, sae_pkg::ST_OK);
					n += stream(1, 0, 0, sae_pkg::ST_OK);
				end
				sae_pkg::ACT_INTERSECT: n = stream(0, 1, 0, sae_pkg::ST_OK);
				sae_pkg::ACT_A_MINUS_B: n = stream(0, 0, 0, sae_pkg::ST_OK);
				sae_pkg::ACT_SYMDIFF: begin
					n = stream(0, 0, 0, sae_pkg::ST_OK);
					n += stream(1, 0, 0, sae_pkg::ST_OK);
				end
				sae_pkg::ACT_COMPL: begin
					ok = 1;
					for (int i = 0; i < a_num; i++)
						if (!holds(1, a_elems[i]))
							ok = 0;
					st = ok ? sae_pkg::ST_OK : sae_pkg::ST_NOT_SUB;
					n = stream(1, 0, !ok, st);
				end
				default: return;
			endcase
			if (n == 0) begin
				push(0, 0, st, 0);
				n = 1;
			end
			pending[$].last = 1'b1;
		endfunction

		task automatic report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task automatic check_result(sae_pkg::out_item_t got);
			sae_pkg::out_item_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending.pop_front();
			if (got.element !== want.element)
				report($sformatf("element %0d, wanted %0d", got.element, want.element));
			if (got.has_element !== want.has_element)
				report($sformatf("has_element %b, wanted %b", got.has_element, want.has_element));
			if (got.last !== want.last)
				report($sformatf("last %b, wanted %b", got.last, want.last));
			if (got.status !== want.status)
				report($sformatf("status %0d, wanted %0d", got.status, want.status));
			if (got.is_subset !== want.is_subset)
				report($sformatf("is_subset %b, wanted %b", got.is_subset, want.is_subset));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sae_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sae_pkg::out_item_t out_data;

	set_scoreboard sets = new();
	bit hold_off = 0;
	int idle_cycles = 0;
	logic [31:0] pool[8];

	set_algebra_engine_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Short gaps mostly, now and then a long one.
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one transaction and hold it until it is accepted.
	task automatic send(logic [3:0] act, logic [31:0] v, bit gaps);
		int g;
		sae_pkg::in_item_t it;
		g = gaps ? gap_length() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		it.action = act;
		it.value = v;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (act <= sae_pkg::ACT_COMPL)
			sets.note_input(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sets.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random transaction: mostly inserts from a small pool so that the sets overlap.
	task automatic random_item();
		int r;
		logic [31:0] v;
		r = $urandom_range(0, 99);
		v = ($urandom_range(0, 3) == 0) ? $urandom() : pool[$urandom_range(0, 7)];
		if (r < 2)
			send(sae_pkg::ACT_CLEAR, $urandom(), 1);
		else if (r < 30)
			send(sae_pkg::ACT_INS_A, v, 1);
		else if (r < 58)
			send(sae_pkg::ACT_INS_B, v, 1);
		else if (r < 60)
			send(4'($urandom_range(9, 15)), $urandom(), 1);
		else
			send(4'($urandom_range(sae_pkg::ACT_SUBSET, sae_pkg::ACT_COMPL)), $urandom(), 1);
	endtask

	// Receiver stall, with one long hold-off requested by the stimulus.
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
	end

	// Result checking.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sets.check_result(out_data);
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < 8; i++)
			pool[i] = $urandom();
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queries, extremes, duplicates, a full set and the complement cases.
		send(sae_pkg::ACT_UNION, 0, 0);
		send(sae_pkg::ACT_COMPL, 0, 0);
		send(sae_pkg::ACT_SUBSET, 0, 0);
		send(sae_pkg::ACT_INS_A, 32'h8000_0000, 0);
		send(sae_pkg::ACT_COMPL, 0, 0);
		send(sae_pkg::ACT_INS_A, 32'h7FFF_FFFF, 0);
		send(sae_pkg::ACT_INS_A, 32'h7FFF_FFFF, 0);
		send(sae_pkg::ACT_INS_B, 32'hFFFF_FFFF, 0);
		send(sae_pkg::ACT_INS_B, 32'h0, 0);
		send(sae_pkg::ACT_INS_B, 32'h7FFF_FFFF, 0);
		for (int k = sae_pkg::ACT_SUBSET; k <= sae_pkg::ACT_COMPL; k++)
			send(4'(k), 32'hFFFF_FFFF, 0);
		send(4'hF, 0, 0);
		for (int i = 0; i < 17; i++)
			send(sae_pkg::ACT_INS_A, 32'h5555_0000 + i, 0);
		send(sae_pkg::ACT_INS_B, 32'hAAAA_AAAA, 0);
		send(sae_pkg::ACT_CLEAR, 0, 0);

		// Fill both sets fully and overlap them to reach the longest streams.
		for (int i = 0; i < 16; i++) begin
			send(sae_pkg::ACT_INS_A, pool[i % 8] + i, 1);
			send(sae_pkg::ACT_INS_B, pool[i % 8] + i + 16 * (i % 2), 1);
		end
		send(sae_pkg::ACT_SYMDIFF, 0, 1);
		send(sae_pkg::ACT_UNION, 0, 1);

		// Long receiver hold-off while the sender keeps offering.
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 10; i++)
				send(4'($urandom_range(sae_pkg::ACT_SUBSET, sae_pkg::ACT_COMPL)), 0, 0);
		join
		drain();
		send(sae_pkg::ACT_CLEAR, 0, 0);

		for (int i = 0; i < 400; i++) begin
			random_item();
			if (i == 200)
				drain();
		end

		drain();
		if (sets.errors == 0 && sets.pending.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

`default_nettype wire
